### rtl/core/minmax_bucket_decimator_assert.svh
// Assertion macros shared by the decimator modules.
// Every check is sampled on clk and switched off while arst_n is low.
`ifndef MINMAX_BUCKET_DECIMATOR_ASSERT_SVH
`define MINMAX_BUCKET_DECIMATOR_ASSERT_SVH

// Same-cycle implication.
`define MMBD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mmbd same-cycle check failed");

// Next-cycle implication.
`define MMBD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mmbd next-cycle check failed");

`endif

### rtl/core/mmbd_pkg.sv
package mmbd_pkg;

	// Fixed field and register widths
	localparam int SAMPLE_COUNT_W = 21;
	localparam int COLUMN_COUNT_W = 13;
	localparam int CFG_DATA_W     = 21;
	localparam int CFG_INDEX_W    = 2;
	localparam int SAMPLE_W       = 32;
	localparam int COLUMN_INDEX_W = 12;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd1;

	// Reset values of the registers
	localparam int SAMPLE_COUNT_RESET = 1024;
	localparam int COLUMN_COUNT_RESET = 256;

	// Results per sample are capped
	localparam int MAX_RUN = 64;
	localparam int RUN_W   = $clog2(MAX_RUN + 1);

	// Parameter defaults
	localparam int DEF_MAX_SAMPLES = 1048576;
	localparam int DEF_MAX_COLUMNS = 4096;
	localparam int DEF_SAMPLE_BITS = 32;

	// Controller to datapath commands
	typedef struct packed {
		logic load_sample;
		logic merge;
		logic emit;
		logic advance;
	} mmbd_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic disabled;
		logic go;
		logic close;
		logic out_free;
	} mmbd_status_t;

endpackage

### rtl/core/mmbd_ctrl.sv
`include "minmax_bucket_decimator_assert.svh"

module mmbd_ctrl
	import mmbd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  mmbd_status_t status,
	output mmbd_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_STEP = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	// Sequence one bucket decision per cycle, holding while the output register is full
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				// drop the beat when the counts disable output
				if (in_valid && !status.disabled) begin
					cmd.load_sample = 1'b1;
					state_d         = ST_STEP;
				end
			end
			ST_STEP: begin
				priority if (!status.go) begin
					cmd.advance = 1'b1;
					state_d     = ST_IDLE;
				end else if (!status.close) begin
					cmd.merge   = 1'b1;
					cmd.advance = 1'b1;
					state_d     = ST_IDLE;
				end else if (status.out_free) begin
					cmd.merge = 1'b1;
					cmd.emit  = 1'b1;
				end else begin
					// hold until the output register frees up
					state_d = state_q;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`MMBD_ASSERT_NEXT(a_load_enters_step, cmd.load_sample, state_q == ST_STEP)
	`MMBD_ASSERT_NOW(a_emit_needs_slot, cmd.emit, status.out_free && status.go && status.close)
	`MMBD_ASSERT_NEXT(a_advance_returns_idle, cmd.advance, in_ready)

endmodule

### rtl/core/mmbd_datapath.sv
`include "minmax_bucket_decimator_assert.svh"

module mmbd_datapath
	import mmbd_pkg::*;
#(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [CFG_INDEX_W-1:0]           cfg_index,
	input  logic [CFG_DATA_W-1:0]            cfg_data,
	input  logic signed [SAMPLE_W-1:0]       sample_value,
	input  mmbd_cmd_t                        cmd,
	output mmbd_status_t                     status,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [COLUMN_INDEX_W-1:0]        column_index,
	output logic signed [SAMPLE_W-1:0]       bucket_min,
	output logic signed [SAMPLE_W-1:0]       bucket_max,
	output logic                             last_in_run,
	output logic                             frame_done
);

	localparam int NW_FULL = $clog2(MAX_SAMPLES + 1);
	localparam int NW      = (NW_FULL < SAMPLE_COUNT_W) ? NW_FULL : SAMPLE_COUNT_W;
	localparam int CW_FULL = $clog2(MAX_COLUMNS + 1);
	localparam int CW      = (CW_FULL < COLUMN_COUNT_W) ? CW_FULL : COLUMN_COUNT_W;
	localparam int AW      = NW + CW + 1;
	localparam int DW      = NW + CW + 6;
	localparam int N_RST   = (SAMPLE_COUNT_RESET > MAX_SAMPLES) ? MAX_SAMPLES
		: SAMPLE_COUNT_RESET;
	localparam int C_RST   = (COLUMN_COUNT_RESET > MAX_COLUMNS) ? MAX_COLUMNS
		: COLUMN_COUNT_RESET;

	// Control state
	logic [NW-1:0]    n_q;
	logic [CW-1:0]    c_q;
	logic [NW-1:0]    pos_q;
	logic [CW-1:0]    col_q;
	logic [AW-1:0]    acc_q;
	logic [AW-1:0]    kc1_q;
	logic             open_q;
	logic [RUN_W-1:0] cnt_q;
	logic             out_valid_q;

	// Payload state
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic [COLUMN_INDEX_W-1:0]     column_index_q;
	logic signed [SAMPLE_BITS-1:0] bucket_min_q;
	logic signed [SAMPLE_BITS-1:0] bucket_max_q;
	logic                          last_q;
	logic                          frame_done_q;

	logic                          cfg_n_hit;
	logic                          cfg_c_hit;
	logic [NW-1:0]                 n_new;
	logic [CW-1:0]                 c_new;
	logic [AW-1:0]                 kc2;
	logic [AW-1:0]                 acc_n;
	logic [AW-1:0]                 acc_2n;
	logic [CW:0]                   col_inc;
	logic                          next_emits;
	logic                          frame_end;
	logic signed [SAMPLE_BITS-1:0] merged_min;
	logic signed [SAMPLE_BITS-1:0] merged_max;

	// Decode and clamp configuration writes
	always_comb begin
		cfg_n_hit = cfg_write && (cfg_index == REG_SAMPLE_COUNT);
		cfg_c_hit = cfg_write && (cfg_index == REG_COLUMN_COUNT);
		if (32'(cfg_data[SAMPLE_COUNT_W-1:0]) > 32'(MAX_SAMPLES)) begin
			n_new = NW'(MAX_SAMPLES);
		end else begin
			n_new = NW'(cfg_data[SAMPLE_COUNT_W-1:0]);
		end
		if (32'(cfg_data[COLUMN_COUNT_W-1:0]) > 32'(MAX_COLUMNS)) begin
			c_new = CW'(MAX_COLUMNS);
		end else begin
			c_new = CW'(cfg_data[COLUMN_COUNT_W-1:0]);
		end
	end

	// Bucket edge compares: acc is col*n, kc1 is (pos+1)*c
	always_comb begin
		kc2        = kc1_q + AW'(c_q);
		acc_n      = acc_q + AW'(n_q);
		acc_2n     = acc_q + (AW'(n_q) << 1);
		col_inc    = (CW + 1)'(col_q) + 1'b1;
		frame_end  = ((NW + 1)'(pos_q) + 1'b1) >= (NW + 1)'(n_q);
		status.disabled = (n_q == '0) || (c_q == '0) || (DW'(c_q) > (DW'(n_q) << 6));
		status.go       = (col_q < c_q) && (cnt_q < RUN_W'(MAX_RUN)) && (acc_q < kc1_q);
		status.close    = acc_n < kc2;
		status.out_free = !out_valid_q || out_ready;
		// look one bucket ahead to flag the final result of this sample
		next_emits = (col_inc < (CW + 1)'(c_q)) && (cnt_q < RUN_W'(MAX_RUN - 1))
			&& (acc_n < kc1_q) && (acc_2n < kc2);
	end

	// Merge the sample into the open bucket
	always_comb begin
		merged_min = (!open_q || (sample_q < min_q)) ? sample_q : min_q;
		merged_max = (!open_q || (sample_q > max_q)) ? sample_q : max_q;
	end

	// Advance the frame position, column and edges
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= NW'(N_RST);
			c_q         <= CW'(C_RST);
			pos_q       <= '0;
			col_q       <= '0;
			acc_q       <= '0;
			kc1_q       <= AW'(C_RST);
			open_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_sample) begin
				cnt_q <= '0;
			end
			if (cmd.merge) begin
				open_q <= !cmd.emit;
			end
			if (cmd.emit) begin
				col_q <= col_q + 1'b1;
				acc_q <= acc_n;
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.advance) begin
				if (frame_end) begin
					pos_q  <= '0;
					col_q  <= '0;
					acc_q  <= '0;
					kc1_q  <= AW'(c_q);
					open_q <= 1'b0;
				end else begin
					pos_q <= pos_q + 1'b1;
					kc1_q <= kc2;
				end
			end
			// restart the frame on a register write
			if (cfg_n_hit || cfg_c_hit) begin
				pos_q  <= '0;
				col_q  <= '0;
				acc_q  <= '0;
				open_q <= 1'b0;
				kc1_q  <= cfg_c_hit ? AW'(c_new) : AW'(c_q);
			end
			if (cfg_n_hit) begin
				n_q <= n_new;
			end
			if (cfg_c_hit) begin
				c_q <= c_new;
			end
			// output register valid
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the sample, running extremes and the output beat
	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			sample_q <= sample_value[SAMPLE_BITS-1:0];
		end
		if (cmd.merge) begin
			min_q <= merged_min;
			max_q <= merged_max;
		end
		if (cmd.emit) begin
			column_index_q <= COLUMN_INDEX_W'(col_q);
			bucket_min_q   <= merged_min;
			bucket_max_q   <= merged_max;
			last_q         <= !next_emits;
			frame_done_q   <= col_inc == (CW + 1)'(c_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign column_index = column_index_q;
	assign bucket_min   = SAMPLE_W'(bucket_min_q);
	assign bucket_max   = SAMPLE_W'(bucket_max_q);
	assign last_in_run  = last_q;
	assign frame_done   = frame_done_q;

	`MMBD_ASSERT_NOW(a_col_in_range, 1'b1, col_q <= c_q)
	`MMBD_ASSERT_NOW(a_pos_in_frame, n_q != '0, pos_q < n_q)
	`MMBD_ASSERT_NEXT(a_emit_fills_slot, cmd.emit, out_valid_q && !open_q)

endmodule

### rtl/core/minmax_bucket_decimator.sv
// Min/max decimator: each frame of sample_count signed samples is cut into
// column_count buckets, and for every bucket one beat carries its index, its
// smallest and largest sample, a frame_done flag on the frame's last bucket
// and a last_in_run flag on the final beat caused by one sample. A sample is
// taken while the bucket sequencer is idle and then holds it, so no new sample
// is taken, until it has closed r buckets, r from 0 to 64, and advanced the
// frame position: the edge compare loop settles one bucket per cycle while
// the output register is not waiting on out_ready. Writing either register
// restarts the frame. With a zero count, or more than 64 columns per sample,
// input beats are taken and dropped.
module minmax_bucket_decimator
	import mmbd_pkg::*;
#(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [CFG_INDEX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [SAMPLE_W-1:0]  sample_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [COLUMN_INDEX_W-1:0]   column_index,
	output logic signed [SAMPLE_W-1:0]  bucket_min,
	output logic signed [SAMPLE_W-1:0]  bucket_max,
	output logic                        last_in_run,
	output logic                        frame_done
);

	mmbd_cmd_t    cmd;
	mmbd_status_t status;

	mmbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	mmbd_datapath #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.MAX_COLUMNS (MAX_COLUMNS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_value (sample_value),
		.cmd          (cmd),
		.status       (status),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.column_index (column_index),
		.bucket_min   (bucket_min),
		.bucket_max   (bucket_max),
		.last_in_run  (last_in_run),
		.frame_done   (frame_done)
	);

endmodule

### tb/sv/minmax_bucket_decimator_tb.sv
`timescale 1ns / 100ps

module minmax_bucket_decimator_tb;
	import mmbd_pkg::*;

	// Indexes that map to no register
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam int     RESET_CYCLES  = 8;
	localparam int     SETTLE_CYCLES = 150;
	localparam int     DRAIN_LIMIT   = 20000;
	localparam int     HOLD_CYCLES   = 400;
	localparam int     PHASE_ITEMS   = 50;
	localparam longint CYCLE_LIMIT   = 600000;

	typedef struct packed {
		logic [COLUMN_INDEX_W-1:0]  column;
		logic signed [SAMPLE_W-1:0] lo;
		logic signed [SAMPLE_W-1:0] hi;
		logic                       last;
		logic                       done;
	} bucket_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample_value = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [COLUMN_INDEX_W-1:0]  column_index;
	logic signed [SAMPLE_W-1:0] bucket_min;
	logic signed [SAMPLE_W-1:0] bucket_max;
	logic                       last_in_run;
	logic                       frame_done;

	// Handshake pacing
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold = 0;

	int     errors = 0;
	longint cycle_count = 0;

	// Buckets the block still owes, oldest first
	bucket_t expected_buckets[$];

	// Shadow of the registers and the frame state
	longint unsigned samples_per_frame = SAMPLE_COUNT_RESET;
	longint unsigned columns_per_frame = COLUMN_COUNT_RESET;
	longint unsigned frame_pos = 0;
	longint unsigned fill_col = 0;
	longint unsigned edge_acc = 0;
	logic signed [SAMPLE_W-1:0] run_lo = '0;
	logic signed [SAMPLE_W-1:0] run_hi = '0;
	bit has_data = 1'b0;

	minmax_bucket_decimator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_value (sample_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.column_index (column_index),
		.bucket_min   (bucket_min),
		.bucket_max   (bucket_max),
		.last_in_run  (last_in_run),
		.frame_done   (frame_done)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Pace out_ready: a long hold first, else random stalls
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Compare each output beat with the oldest expected bucket
	always @(posedge clk) begin
		bucket_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_buckets.size() == 0) begin
				$display("%0t: unexpected beat column %h min %h max %h", $time,
					column_index, bucket_min, bucket_max);
				errors++;
			end else begin
				want = expected_buckets.pop_front();
				check_field("column_index", 32'(want.column), 32'(column_index));
				check_field("bucket_min", want.lo, bucket_min);
				check_field("bucket_max", want.hi, bucket_max);
				check_field("last_in_run", 32'(want.last), 32'(last_in_run));
				check_field("frame_done", 32'(want.done), 32'(frame_done));
			end
		end
	end

	function automatic void restart_frame();
		frame_pos = 0;
		fill_col = 0;
		edge_acc = 0;
		has_data = 1'b0;
	endfunction

	// Fold one sample into the open bucket and queue every bucket it closes
	task automatic decimate_sample(input logic signed [SAMPLE_W-1:0] v);
		longint unsigned n;
		longint unsigned c;
		longint unsigned k;
		bucket_t closed[$];
		bucket_t b;
		bit stop;
		n = (samples_per_frame > DEF_MAX_SAMPLES) ? DEF_MAX_SAMPLES : samples_per_frame;
		c = (columns_per_frame > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : columns_per_frame;
		k = frame_pos;
		stop = 1'b0;
		// drop samples while the counts make no frame
		if (n == 0 || c == 0 || c > MAX_RUN * n)
			return;
		while (!stop && fill_col < c && closed.size() < MAX_RUN) begin
			if (!(edge_acc < (k + 1) * c)) begin
				stop = 1'b1;
			end else begin
				if (!has_data) begin
					run_lo = v;
					run_hi = v;
					has_data = 1'b1;
				end else begin
					if (v < run_lo) run_lo = v;
					if (v > run_hi) run_hi = v;
				end
				if (!(edge_acc + n < (k + 2) * c)) begin
					stop = 1'b1;
				end else begin
					b.column = fill_col[COLUMN_INDEX_W-1:0];
					b.lo = run_lo;
					b.hi = run_hi;
					b.last = 1'b0;
					b.done = (fill_col + 1 == c);
					closed.push_back(b);
					has_data = 1'b0;
					fill_col++;
					edge_acc += n;
				end
			end
		end
		if (closed.size() > 0)
			closed[closed.size() - 1].last = 1'b1;
		foreach (closed[i])
			expected_buckets.push_back(closed[i]);
		if (k + 1 >= n)
			restart_frame();
		else
			frame_pos = k + 1;
	endtask

	// Offer one sample beat; entered and left at a falling edge
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample_value <= value;
		do @(posedge clk); while (!in_ready);
		decimate_sample(value);
		@(negedge clk);
	endtask

	// Pause input until every bucket is out and the block has gone quiet
	task automatic settle();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (expected_buckets.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
		case (index)
			REG_SAMPLE_COUNT: begin
				samples_per_frame = 64'(data);
				restart_frame();
			end
			REG_COLUMN_COUNT: begin
				columns_per_frame = 64'(data[COLUMN_COUNT_W-1:0]);
				restart_frame();
			end
			default: ;
		endcase
	endtask

	// Upper data bits above the column field are junk the block must ignore
	task automatic configure(input logic [SAMPLE_COUNT_W-1:0] n,
			input logic [COLUMN_COUNT_W-1:0] c);
		settle();
		write_reg(REG_SAMPLE_COUNT, n);
		write_reg(REG_COLUMN_COUNT, {8'($urandom_range(255)), c});
	endtask

	function automatic logic signed [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(11))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Reset counts: four samples per bucket
	task automatic test_reset_defaults();
		send_sample(32'sh8000_0000);
		send_sample(32'sh7FFF_FFFF);
		send_sample(32'sh0000_0000);
		send_sample(-32'sd1);
		send_sample(32'sd1);
		send_sample(-32'sd2);
		send_sample(32'sh7FFF_FFFF);
		send_sample(32'sh8000_0000);
	endtask

	// Zero counts and too many columns drop every sample
	task automatic test_disabled_counts();
		configure(0, 16);
		repeat (2) send_sample(random_sample());
		configure(4, 0);
		repeat (2) send_sample(random_sample());
		configure(1, 65);
		repeat (2) send_sample(random_sample());
	endtask

	// Largest run: every sample closes 64 buckets
	task automatic test_full_run();
		configure(2, 128);
		send_sample(32'sh7FFF_FFFF);
		send_sample(32'sh8000_0000);
	endtask

	// Oversized column count is clamped, which makes the frame legal
	task automatic test_column_clamp();
		configure(64, 13'h1FFF);
		send_sample(random_sample());
	endtask

	// More columns than samples: one sample closes several buckets
	task automatic test_more_columns();
		configure(3, 7);
		repeat (3) send_sample(random_sample());
	endtask

	// Writes to unused indexes leave the frame running
	task automatic test_spare_index();
		configure(4, 2);
		send_sample(random_sample());
		settle();
		write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
		write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
		repeat (3) send_sample(random_sample());
	endtask

	task automatic pick_random_config();
		logic [SAMPLE_COUNT_W-1:0] n;
		logic [COLUMN_COUNT_W-1:0] c;
		case ($urandom_range(9))
			0, 1, 2: begin
				n = SAMPLE_COUNT_W'($urandom_range(1, 16));
				c = COLUMN_COUNT_W'($urandom_range(1, 4 * n + 2));
			end
			3, 4: begin
				n = SAMPLE_COUNT_W'($urandom_range(1, 4));
				c = COLUMN_COUNT_W'($urandom_range(32 * n, 64 * n));
			end
			5, 6: begin
				n = SAMPLE_COUNT_W'($urandom_range(2, 40));
				c = COLUMN_COUNT_W'($urandom_range(1, n));
			end
			7: begin
				case ($urandom_range(4))
					0: begin n = 1; c = 64; end
					1: begin n = 1; c = 1; end
					2: begin n = 21'h1F_FFFF; c = 13'h1FFF; end
					3: begin n = 64; c = 4096; end
					default: begin n = DEF_MAX_SAMPLES; c = 1; end
				endcase
			end
			8: begin
				case ($urandom_range(2))
					0: begin n = 0; c = COLUMN_COUNT_W'($urandom); end
					1: begin n = SAMPLE_COUNT_W'($urandom); c = 0; end
					default: begin
						n = SAMPLE_COUNT_W'($urandom_range(1, 60));
						c = COLUMN_COUNT_W'($urandom_range(64 * n + 1, 64 * n + 64));
					end
				endcase
			end
			default: begin
				n = SAMPLE_COUNT_W'($urandom_range(1, 24));
				c = COLUMN_COUNT_W'($urandom_range(1, 3 * n));
			end
		endcase
		configure(n, c);
		// sometimes poke an unused index as well
		if ($urandom_range(5) == 0)
			write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
				CFG_DATA_W'($urandom));
	endtask

	// Bursts of random samples under changing counts, some spanning frames
	task automatic run_random_phase(input int tx_pct, input int rx_pct);
		int sent;
		int burst;
		longint unsigned n_eff;
		longint unsigned c_eff;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			if (sent == 0 || $urandom_range(3) != 0)
				pick_random_config();
			n_eff = (samples_per_frame > DEF_MAX_SAMPLES) ? DEF_MAX_SAMPLES
				: samples_per_frame;
			c_eff = (columns_per_frame > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS
				: columns_per_frame;
			burst = $urandom_range(4, 24);
			repeat (burst) send_sample(random_sample());
			if (n_eff != 0 && c_eff != 0 && c_eff <= MAX_RUN * n_eff)
				sent += burst;
		end
		settle();
	endtask

	// Hold the output side while the sender keeps offering long runs
	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		configure(1, 64);
		rx_hold = HOLD_CYCLES;
		repeat (6) send_sample(random_sample());
		settle();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_idle_pct = 29;
		rx_idle_pct = 45;
		test_reset_defaults();
		test_disabled_counts();
		test_full_run();
		test_column_clamp();
		test_more_columns();
		test_spare_index();

		run_random_phase(29, 45);
		run_random_phase(45, 29);
		run_random_phase(0, 0);
		test_backpressure();

		settle();
		if (expected_buckets.size() != 0) begin
			$display("%0t: %0d expected buckets never arrived", $time,
				expected_buckets.size());
			errors += expected_buckets.size();
		end
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
